/* hdl/ssr_pkg.sv */
// Shared constants and types of the streaming find-and-replace block.
package ssr_pkg;

  // Default limits on the pattern and replacement lengths, in bytes.
  localparam int unsigned SSR_MAX_PATTERN_BYTES     = 8;
  localparam int unsigned SSR_MAX_REPLACEMENT_BYTES = 8;

  // Configuration port widths, fixed by the register set.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_PATTERN      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_TEXT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // Control that goes with a burst handed to the output stage.
  typedef struct packed {
    logic load;      // a burst of one or more results is handed over
    logic end_mark;  // the last result of the burst ends the text
    logic bare;      // the burst is a single end mark without a byte
  } burst_ctl_t;

endpackage

/* hdl/ssr_cell.sv */
// One byte cell of the pending window: holds a byte and compares it with its pattern byte.
module ssr_cell (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       tail_i,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] shift_byte_i,
  input  logic [7:0] pat_byte_i,
  output logic [7:0] cur_byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q;

  // The cell at the tail position sees the incoming byte as already appended.
  assign cur_byte_o = tail_i ? in_byte_i : byte_q;
  assign hit_o      = (cur_byte_o == pat_byte_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= shift_byte_i;
    end
  end

endmodule

/* hdl/ssr_burst.sv */
// Output stage: holds one burst of results and sends them one item per cycle while the receiver is ready.
module ssr_burst #(
  parameter int unsigned Depth = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssr_pkg::burst_ctl_t        ctl_i,
  input  logic [$clog2(Depth+1)-1:0] len_i,
  input  logic [7:0]                 bytes_i [Depth],
  output logic                       can_load_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [7:0]                 m_byte_o,
  output logic                       m_byte_valid_o,
  output logic                       m_last_o
);

  localparam int unsigned LenW = $clog2(Depth+1);

  logic [7:0]      bytes_q [Depth];
  logic [7:0]      bytes_d [Depth];
  logic [LenW-1:0] rem_q, rem_d;
  logic            end_q, end_d;
  logic            bare_q, bare_d;
  logic            pop;

  assign m_valid_o      = (rem_q != '0);
  assign pop            = m_valid_o && m_ready_i;
  assign can_load_o     = (rem_q == '0) || ((rem_q == LenW'(1)) && m_ready_i);
  assign m_byte_o       = bare_q ? 8'h00 : bytes_q[0];
  assign m_byte_valid_o = !bare_q;
  assign m_last_o       = end_q && (rem_q == LenW'(1));

  always_comb begin
    rem_d  = rem_q;
    end_d  = end_q;
    bare_d = bare_q;
    for (int i = 0; i < int'(Depth); i++) begin
      bytes_d[i] = bytes_q[i];
    end
    if (ctl_i.load) begin
      rem_d  = len_i;
      end_d  = ctl_i.end_mark;
      bare_d = ctl_i.bare;
      for (int i = 0; i < int'(Depth); i++) begin
        bytes_d[i] = bytes_i[i];
      end
    end else if (pop) begin
      rem_d = rem_q - LenW'(1);
      for (int i = 0; i < int'(Depth) - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      end_q  <= 1'b0;
      bare_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      end_q  <= end_d;
      bare_q <= bare_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= LenW'(Depth))
    else $error("burst count beyond buffer depth");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |=> m_valid_o)
    else $error("loaded burst not presented");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && bare_q) |-> m_last_o)
    else $error("bare end mark without last flag");

endmodule

/* hdl/stream_substring_replace.sv */
// Top level of the streaming find-and-replace block.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_axis_tvalid_i/tready_o  tdata = in_byte, tlast = in_end
//  m_axis    out        m_axis_tvalid_o/tready_i  tdata = out_byte, tuser = byte_valid,
//                                                 tlast = out_end
//  cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// An item is taken in every cycle as long as each item yields at most one result and the
// output is not stalled; an item that yields more holds the input until its last result
// is being taken, as the output stage sends one result per cycle from its burst buffer.
// The window update and the match test take place in the cycle of acceptance; the first
// result of an item is registered and appears on the output in the cycle after.
// Reset clears the configuration to its defaults, the pending count and the output stage;
// the window bytes themselves are not reset. No clearing pass is needed.
// A stall on the output holds the burst buffer, and the input is held off until the last
// result of the burst is being taken.
module stream_substring_replace #(
  parameter int unsigned MAX_PATTERN_BYTES     = ssr_pkg::SSR_MAX_PATTERN_BYTES,
  parameter int unsigned MAX_REPLACEMENT_BYTES = ssr_pkg::SSR_MAX_REPLACEMENT_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,   // [7:0] in_byte
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,   // [7:0] out_byte
  output logic                             m_axis_tuser_o,   // [0] byte_valid
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssr_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // The burst buffer must hold either a full replacement or a full window flush.
  localparam int unsigned BurstDepth = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
                                       MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
  localparam int unsigned CntW       = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned LenW       = $clog2(BurstDepth + 1);

  // Configuration registers.
  logic [ssr_pkg::CFG_DATA_W-1:0] pattern_q, pattern_d;
  logic [3:0]                     plen_cfg_q, plen_cfg_d;
  logic [ssr_pkg::CFG_DATA_W-1:0] repl_q, repl_d;
  logic [3:0]                     rlen_cfg_q, rlen_cfg_d;

  // Window control.
  logic [CntW-1:0] count_q, count_d;
  logic [3:0]      plen4;
  logic [3:0]      rlen4;
  logic [CntW-1:0] plen_eff;
  logic [CntW-1:0] cnt_app;
  logic [CntW-1:0] shift_k;
  logic            hit_all;
  logic            match;
  logic            in_acc;
  logic            can_load;

  logic [7:0] cur_byte   [MAX_PATTERN_BYTES];
  logic [7:0] shift_byte [MAX_PATTERN_BYTES];
  logic       hit        [MAX_PATTERN_BYTES];
  logic       tail       [MAX_PATTERN_BYTES];

  // Burst handed to the output stage.
  logic [7:0]          burst_bytes [BurstDepth];
  logic [LenW-1:0]     burst_len;
  logic [LenW-1:0]     raw_len;
  ssr_pkg::burst_ctl_t burst_ctl;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = can_load;
  assign in_acc          = s_axis_tvalid_i && can_load;

  // Configuration writes; the length registers hold only their low bits, as the lengths are 4 bits.
  always_comb begin
    pattern_d  = pattern_q;
    plen_cfg_d = plen_cfg_q;
    repl_d     = repl_q;
    rlen_cfg_d = rlen_cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssr_pkg::REG_MATCH_PATTERN:      pattern_d  = cfg_data_i;
        ssr_pkg::REG_PATTERN_LENGTH:     plen_cfg_d = cfg_data_i[3:0];
        ssr_pkg::REG_REPLACEMENT_TEXT:   repl_d     = cfg_data_i;
        ssr_pkg::REG_REPLACEMENT_LENGTH: rlen_cfg_d = cfg_data_i[3:0];
      endcase
    end
  end

  // Effective lengths: a zero pattern length acts as one, and both are clipped at the limit.
  always_comb begin
    priority if (plen_cfg_q == 4'd0) begin
      plen4 = 4'd1;
    end else if (plen_cfg_q > 4'(MAX_PATTERN_BYTES)) begin
      plen4 = 4'(MAX_PATTERN_BYTES);
    end else begin
      plen4 = plen_cfg_q;
    end
    if (rlen_cfg_q > 4'(MAX_REPLACEMENT_BYTES)) begin
      rlen4 = 4'(MAX_REPLACEMENT_BYTES);
    end else begin
      rlen4 = rlen_cfg_q;
    end
  end

  assign plen_eff = CntW'(plen4);

  // The count never exceeds the pattern limit minus one, so the new byte always fits.
  assign cnt_app = count_q + CntW'(1);

  // Number of oldest bytes that leave the window when there is no match. Normally this
  // is zero or one; after the pattern length has been shrunk it can be larger.
  always_comb begin
    if (cnt_app >= plen_eff) begin
      shift_k = cnt_app - plen_eff + CntW'(1);
    end else begin
      shift_k = '0;
    end
  end

  // The row of cells: each holds one window byte and compares it with its pattern byte.
  for (genvar g = 0; g < int'(MAX_PATTERN_BYTES); g++) begin : g_cell
    assign tail[g] = (count_q == CntW'(g));
    ssr_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (in_acc),
      .tail_i       (tail[g]),
      .in_byte_i    (s_axis_tdata_i),
      .shift_byte_i (shift_byte[g]),
      .pat_byte_i   (pattern_q[8*g +: 8]),
      .cur_byte_o   (cur_byte[g]),
      .hit_o        (hit[g])
    );
  end

  // Each cell takes the byte from the cell shift_k places further along.
  always_comb begin
    for (int i = 0; i < int'(MAX_PATTERN_BYTES); i++) begin
      shift_byte[i] = cur_byte[i];
      for (int j = 0; j < int'(MAX_PATTERN_BYTES); j++) begin
        if (j == i + int'(shift_k)) begin
          shift_byte[i] = cur_byte[j];
        end
      end
    end
  end

  // A match needs exactly one pattern length of bytes, all equal to the pattern.
  always_comb begin
    hit_all = 1'b1;
    for (int i = 0; i < int'(MAX_PATTERN_BYTES); i++) begin
      if ((CntW'(i) < plen_eff) && !hit[i]) begin
        hit_all = 1'b0;
      end
    end
  end

  assign match = (cnt_app == plen_eff) && hit_all;

  // Results of the item: the replacement on a match, otherwise the oldest bytes that
  // leave the window, or all of them at the end of the text.
  always_comb begin
    for (int i = 0; i < int'(BurstDepth); i++) begin
      burst_bytes[i] = 8'h00;
      if (match) begin
        if (i < int'(MAX_REPLACEMENT_BYTES)) begin
          burst_bytes[i] = repl_q[8*i +: 8];
        end
      end else if (i < int'(MAX_PATTERN_BYTES)) begin
        burst_bytes[i] = cur_byte[i];
      end
    end
    priority if (match) begin
      raw_len = LenW'(rlen4);
    end else if (s_axis_tlast_i) begin
      raw_len = LenW'(cnt_app);
    end else begin
      raw_len = LenW'(shift_k);
    end
    // An end of text that yields nothing still sends a single bare end mark.
    burst_ctl.bare     = s_axis_tlast_i && (raw_len == '0);
    burst_ctl.end_mark = s_axis_tlast_i;
    burst_len          = burst_ctl.bare ? LenW'(1) : raw_len;
    burst_ctl.load     = in_acc && (burst_len != '0);
  end

  always_comb begin
    count_d = count_q;
    if (in_acc) begin
      if (match || s_axis_tlast_i) begin
        count_d = '0;
      end else begin
        count_d = cnt_app - shift_k;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      plen_cfg_q <= 4'd1;
      repl_q     <= '0;
      rlen_cfg_q <= 4'd0;
      count_q    <= '0;
    end else begin
      pattern_q  <= pattern_d;
      plen_cfg_q <= plen_cfg_d;
      repl_q     <= repl_d;
      rlen_cfg_q <= rlen_cfg_d;
      count_q    <= count_d;
    end
  end

  ssr_burst #(
    .Depth (BurstDepth)
  ) u_burst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (burst_ctl),
    .len_i          (burst_len),
    .bytes_i        (burst_bytes),
    .can_load_o     (can_load),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_byte_o       (m_axis_tdata_o),
    .m_byte_valid_o (m_axis_tuser_o),
    .m_last_o       (m_axis_tlast_o)
  );

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CntW'(MAX_PATTERN_BYTES))
    else $error("pending count reached the window size");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (count_q == '0))
    else $error("window not empty after end of text");

  a_match_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && match) |=> (count_q == '0))
    else $error("window not empty after a match");

endmodule

/* test/tb_stream_substring_replace.sv */
// Self-checking testbench of the streaming find-and-replace block.
module tb_stream_substring_replace;

  // One result of the rewritten text, as it leaves the master side.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_end;
  } text_result_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [7:0]                      s_axis_tdata_i  = '0;   // [7:0] in_byte
  logic                            s_axis_tlast_i  = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [7:0]                      m_axis_tdata_o;         // [7:0] out_byte
  logic                            m_axis_tuser_o;         // [0] byte_valid
  logic                            m_axis_tlast_o;
  logic                            cfg_valid_i     = 1'b0;
  logic                            cfg_ready_o;
  logic [ssr_pkg::CFG_INDEX_W-1:0] cfg_index_i     = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0]  cfg_data_i      = '0;

  // Our own copy of the rule registers and of the pending window.
  logic [63:0]    pattern_q     = '0;
  logic [3:0]     pattern_len_q = 4'd1;
  logic [63:0]    repl_q        = '0;
  logic [3:0]     repl_len_q    = '0;
  logic [7:0]     window_bytes [ssr_pkg::SSR_MAX_PATTERN_BYTES];
  int unsigned    window_fill   = 0;

  text_result_t   rewrite_q [$];   // rewritten text still owed by the block
  logic [7:0]     text_buf [$];    // text about to be sent
  bit             steady        = 1'b0;
  int unsigned    mismatch_count = 0;

  stream_substring_replace dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A pattern length of zero behaves as one; anything above the maximum is clipped.
  function automatic int unsigned active_pattern_len();
    if (pattern_len_q == 4'd0) return 1;
    if (pattern_len_q > ssr_pkg::SSR_MAX_PATTERN_BYTES) return ssr_pkg::SSR_MAX_PATTERN_BYTES;
    return pattern_len_q;
  endfunction

  // Appends one result to the tail of the owed text.
  function automatic void owe_result(input logic [7:0] b, input logic valid, input logic last);
    text_result_t r;
    r.out_byte   = b;
    r.byte_valid = valid;
    r.out_end    = last;
    rewrite_q.insert(rewrite_q.size(), r);
  endfunction

  function automatic void shift_out_oldest();
    owe_result(window_bytes[0], 1'b1, 1'b0);
    for (int i = 0; i < ssr_pkg::SSR_MAX_PATTERN_BYTES - 1; i++) begin
      window_bytes[i] = window_bytes[i + 1];
    end
    window_fill--;
  endfunction

  // Works out the characters that one accepted text byte releases.
  function automatic void predict_rewrite(input logic [7:0] b, input logic last);
    int unsigned plen;
    int unsigned rlen;
    int unsigned start_size;
    bit          hit;
    plen = active_pattern_len();
    rlen = (repl_len_q > ssr_pkg::SSR_MAX_REPLACEMENT_BYTES) ?
           ssr_pkg::SSR_MAX_REPLACEMENT_BYTES : repl_len_q;
    start_size = rewrite_q.size();
    if (window_fill < ssr_pkg::SSR_MAX_PATTERN_BYTES) begin
      window_bytes[window_fill] = b;
      window_fill++;
    end
    // A match is only tried when the window holds exactly one pattern's worth;
    // after the pattern has been shortened it may hold more, and then no test happens.
    if (window_fill == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++) begin
        if (window_bytes[i] !== pattern_q[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) owe_result(repl_q[8*i +: 8], 1'b1, 1'b0);
        window_fill = 0;
      end
    end
    while (window_fill >= plen) shift_out_oldest();
    if (last) begin
      while (window_fill > 0) shift_out_oldest();
      // An end that releases nothing still owes a bare end mark.
      if (rewrite_q.size() == start_size) owe_result(8'h00, 1'b0, 1'b1);
      else rewrite_q[rewrite_q.size() - 1].out_end = 1'b1;
    end
  endfunction

  // The receiver stalls about a quarter of the time, except during the steady stretch.
  always @(posedge clk_i) m_axis_tready_i <= steady || ($urandom_range(99) >= 26);

  // Every result taken from the master side is held against the oldest expectation.
  always @(posedge clk_i) begin
    text_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (rewrite_q.size() == 0) begin
        $error("result with nothing expected: out_byte %h, byte_valid %b, out_end %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_count++;
      end else begin
        want = rewrite_q.pop_front();
        if (m_axis_tdata_o !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== want.out_end) begin
          $error("out_end: expected %b, got %b", want.out_end, m_axis_tlast_o);
          mismatch_count++;
        end
      end
    end
  end

  // Offers one text item, after a random gap, and predicts once it is taken.
  // Valid is left high on acceptance so that back-to-back items need no toggling.
  task automatic send_item(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 26) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_rewrite(b, last);
  endtask

  task automatic send_text(input bit close);
    foreach (text_buf[i]) send_item(text_buf[i], close && (i == text_buf.size() - 1));
    text_buf.delete();
  endtask

  // Holds the sender off until every owed result has come, then lets the block
  // finish any item that released nothing.
  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [ssr_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ssr_pkg::REG_MATCH_PATTERN:      pattern_q     = value;
      ssr_pkg::REG_PATTERN_LENGTH:     pattern_len_q = value[3:0];
      ssr_pkg::REG_REPLACEMENT_TEXT:   repl_q        = value;
      ssr_pkg::REG_REPLACEMENT_LENGTH: repl_len_q    = value[3:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_rule(input logic [63:0] pat, input logic [63:0] plen_word,
                          input logic [63:0] repl, input logic [63:0] rlen_word);
    settle_block();
    write_register(ssr_pkg::REG_MATCH_PATTERN, pat);
    write_register(ssr_pkg::REG_PATTERN_LENGTH, plen_word);
    write_register(ssr_pkg::REG_REPLACEMENT_TEXT, repl);
    write_register(ssr_pkg::REG_REPLACEMENT_LENGTH, rlen_word);
  endtask

  // Out of reset the rule is a one-byte pattern of zero with an empty replacement,
  // so zero bytes vanish; a text of one zero byte leaves only a bare end mark.
  task automatic test_reset_defaults();
    text_buf = {8'h00, 8'h41, 8'h00};
    send_text(1'b1);
    text_buf = {8'h00};
    send_text(1'b1);
  endtask

  // Two-byte pattern, three-byte replacement, with a pause in mid-text.
  task automatic test_short_match();
    set_rule(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    text_buf = {8'h61, 8'h62, 8'h63, 8'h61};
    send_text(1'b0);
    settle_block();
    text_buf = {8'h61, 8'h62};
    send_text(1'b1);
  endtask

  // Longest pattern and replacement, with the byte extremes inside them.
  task automatic test_full_width();
    set_rule(64'h80FF_7F00_0102_FE55, 64'd8, 64'hA5C3_FF00_8001_7E3C, 64'd8);
    for (int i = 0; i < 8; i++) text_buf.insert(text_buf.size(), pattern_q[8*i +: 8]);
    send_text(1'b1);
  endtask

  // A zero pattern length acts as one, an oversized replacement length as the maximum.
  task automatic test_length_clamps();
    set_rule(64'h0000_0000_0000_00C4, 64'd0, 64'h1122_3344_5566_7788, 64'd15);
    text_buf = {8'hC4};
    send_text(1'b1);
  endtask

  // Five pattern bytes are left pending, then the pattern is cut to two bytes:
  // the next item flushes the surplus without a match test, the one after matches.
  task automatic test_shrink_mid_text();
    set_rule(64'h4847_4645_4443_4241, 64'd8, 64'h7A79, 64'd2);
    text_buf = {8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
    send_text(1'b0);
    settle_block();
    write_register(ssr_pkg::REG_PATTERN_LENGTH, 64'd2);
    text_buf = {8'h41, 8'h42};
    send_text(1'b1);
  endtask

  // Random rules and texts built mostly from whole and partial copies of the pattern.
  // The first phase uses the shortest lengths, the last the longest; length words
  // carry junk above the four bits that count.
  task automatic test_random_texts();
    logic [63:0] pat;
    logic [3:0]  plen4;
    logic [3:0]  rlen4;
    int unsigned plen;
    int unsigned sent;
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 8; i++) begin
        pat[8*i +: 8] = (phase % 2 == 1) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(8'h61, 8'h64));
      end
      plen4 = (phase == 0) ? 4'd1 : (phase == 5) ? 4'd8 : 4'($urandom_range(15));
      rlen4 = (phase == 0) ? 4'd0 : (phase == 5) ? 4'd8 : 4'($urandom_range(15));
      set_rule(pat, {$urandom(), 28'($urandom()), plen4},
               {$urandom(), $urandom()}, {$urandom(), 28'($urandom()), rlen4});
      steady = (phase == 2);
      plen = active_pattern_len();
      sent = 0;
      while (sent < 16) begin
        target = $urandom_range(1, 16);
        while (text_buf.size() < target) begin
          pick = $urandom_range(99);
          if (pick < 50) begin
            for (int i = 0; i < plen; i++) begin
              text_buf.insert(text_buf.size(), pattern_q[8*i +: 8]);
            end
          end else if (pick < 65) begin
            cut = $urandom_range(plen);
            for (int i = 0; i < cut; i++) begin
              text_buf.insert(text_buf.size(), pattern_q[8*i +: 8]);
            end
          end else if (pick < 80) begin
            cut = $urandom_range(7);
            text_buf.insert(text_buf.size(), pattern_q[8*cut +: 8]);
          end else begin
            text_buf.insert(text_buf.size(), 8'($urandom_range(255)));
          end
        end
        sent += text_buf.size();
        send_text(1'b1);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_short_match();
    test_full_width();
    test_length_clamps();
    test_shrink_mid_text();
    test_random_texts();
    settle_block();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("stream_substring_replace: match");
    end else begin
      $display("stream_substring_replace: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2400000;
    $display("stream_substring_replace: mismatch");
    $finish;
  end

endmodule

/* sim.f */
hdl/ssr_pkg.sv
hdl/ssr_cell.sv
hdl/ssr_burst.sv
hdl/stream_substring_replace.sv
test/tb_stream_substring_replace.sv
